[src/lsbx_pkg.sv]
// Shared types and codes for the LSB payload extractor.
`timescale 1ns / 1ps

package lsbx_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] kind_type;

   localparam phase_type PH_HEADER   = 3'd0;
   localparam phase_type PH_MAGIC    = 3'd1;
   localparam phase_type PH_EXT_SIZE = 3'd2;
   localparam phase_type PH_EXT      = 3'd3;
   localparam phase_type PH_SIZE     = 3'd4;
   localparam phase_type PH_PAYLOAD  = 3'd5;
   localparam phase_type PH_DONE     = 3'd6;

   localparam kind_type KIND_EXT     = 2'd0;
   localparam kind_type KIND_PAYLOAD = 2'd1;
   localparam kind_type KIND_FAIL    = 2'd2;

   localparam logic [1:0] REG_HEADER_BYTES = 2'd0;
   localparam logic [1:0] REG_MAGIC_LENGTH = 2'd1;
   localparam logic [1:0] REG_MAGIC_CHARS  = 2'd2;

   localparam logic [7:0]  HEADER_BYTES_RESET = 8'd54;
   localparam logic [3:0]  MAGIC_LENGTH_RESET = 4'd2;
   localparam logic [63:0] MAGIC_CHARS_RESET  = 64'd8746;

endpackage

[src/lsbx_req_if.sv]
// Input channel: one raw image byte per item.
`timescale 1ns / 1ps

interface lsbx_req_if;
   logic       valid;
   logic       ready;
   logic       start_req;
   logic [7:0] pixel_byte;

   modport source (output valid, output start_req, output pixel_byte, input ready);
   modport sink   (input valid, input start_req, input pixel_byte, output ready);
endinterface

[src/lsbx_rsp_if.sv]
// Result channel: decoded characters, payload bytes and failure items.
`timescale 1ns / 1ps

interface lsbx_rsp_if;
   logic                valid;
   logic                ready;
   lsbx_pkg::kind_type  out_kind;
   logic [7:0]          out_byte;
   logic                last;

   modport source (output valid, output out_kind, output out_byte, output last, input ready);
   modport sink   (input valid, input out_kind, input out_byte, input last, output ready);
endinterface

[src/lsb_stego_payload_extractor.sv]
// Top level of the LSB steganography payload extractor.
`timescale 1ns / 1ps

// Takes an image file one byte per item and recovers data hidden in the
// least significant bits. Assert start_req with the first byte of each
// image. After header_bytes skipped bytes the block checks magic_length
// (clamped to 1 to 8) magic characters against magic_chars, reads a 32-bit
// extension length (1 to MAX_EXTENSION) and emits the extension characters,
// then reads a 32-bit payload length and emits the payload bytes, last set
// on the final one. A bad magic or length gives one failure item (kind 2,
// byte 0, last set); later bytes are dropped until the next start_req.
// Throughput is one item per clock while no result waits. A byte is held
// in the input register, then decode loads the result register when the
// result slot is free or drains. While a result waits, the input register
// takes one more item only if empty, then stalls until the result is taken.
// Write the configuration registers only while no item is in flight.

module lsb_stego_payload_extractor #(
   parameter int MAX_EXTENSION = 4
) (
   input  logic        clock,
   input  logic        reset,
   lsbx_req_if.sink    req_chan,
   lsbx_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   // Configuration registers
   logic [7:0]  header_bytes_ff;
   logic [3:0]  magic_length_ff;
   logic [63:0] magic_chars_ff;

   // Input register
   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_byte_ff;

   // Parse state
   lsbx_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  header_count_ff, header_count_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [31:0] bit_shift_ff, bit_shift_in;
   logic [3:0]  magic_index_ff, magic_index_in;
   logic        magic_match_ff, magic_match_in;
   logic [7:0]  extension_left_ff, extension_left_in;
   logic [30:0] payload_left_ff, payload_left_in;

   // Result register
   logic                out_valid_ff;
   lsbx_pkg::kind_type  out_kind_ff, out_kind_in;
   logic [7:0]          out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   logic                emit_in;

   logic advance;

   // Move the held item through decode when the result slot is free or drains.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.out_kind = out_kind_ff;
   assign rsp_chan.out_byte = out_byte_ff;
   assign rsp_chan.last     = out_last_ff;

   // Configuration writes; indexes beyond the list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_bytes_ff <= lsbx_pkg::HEADER_BYTES_RESET;
         magic_length_ff <= lsbx_pkg::MAGIC_LENGTH_RESET;
         magic_chars_ff  <= lsbx_pkg::MAGIC_CHARS_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lsbx_pkg::REG_HEADER_BYTES: header_bytes_ff <= csr_write_data[7:0];
            lsbx_pkg::REG_MAGIC_LENGTH: magic_length_ff <= csr_write_data[3:0];
            lsbx_pkg::REG_MAGIC_CHARS:  magic_chars_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register: hold one item ahead of the decode step.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_start_ff <= req_chan.start_req;
         in_byte_ff  <= req_chan.pixel_byte;
      end
   end

   // Decode one byte: header skip, bit gathering and field handling.
   always_comb begin
      logic        full;
      logic [3:0]  mlen;
      logic [2:0]  sel;
      logic [7:0]  expect_ch;
      logic [7:0]  ch;
      logic [3:0]  mi_next;
      logic [7:0]  el_next;
      logic [30:0] pl_next;
      logic        go;

      full      = 1'b0;
      mlen      = 4'd1;
      sel       = 3'd0;
      expect_ch = 8'd0;
      ch        = 8'd0;
      mi_next   = 4'd0;
      el_next   = 8'd0;
      pl_next   = 31'd0;
      go        = 1'b1;

      emit_in     = 1'b0;
      out_kind_in = lsbx_pkg::KIND_FAIL;
      out_byte_in = 8'd0;
      out_last_in = 1'b0;

      // Restart on a start flag
      if (in_start_ff) begin
         phase_in          = lsbx_pkg::PH_HEADER;
         header_count_in   = 8'd0;
         bit_count_in      = 5'd0;
         bit_shift_in      = 32'd0;
         magic_index_in    = 4'd0;
         magic_match_in    = 1'b1;
         extension_left_in = 8'd0;
         payload_left_in   = 31'd0;
      end else begin
         phase_in          = phase_ff;
         header_count_in   = header_count_ff;
         bit_count_in      = bit_count_ff;
         bit_shift_in      = bit_shift_ff;
         magic_index_in    = magic_index_ff;
         magic_match_in    = magic_match_ff;
         extension_left_in = extension_left_ff;
         payload_left_in   = payload_left_ff;
      end

      if (phase_in == lsbx_pkg::PH_HEADER) begin
         if (header_count_in < header_bytes_ff) begin
            header_count_in = header_count_in + 8'd1;
            go = 1'b0;
         end else begin
            phase_in       = lsbx_pkg::PH_MAGIC;
            bit_count_in   = 5'd0;
            bit_shift_in   = 32'd0;
            magic_index_in = 4'd0;
            magic_match_in = 1'b1;
         end
      end

      // Finished phase and the unused code ignore input
      if (phase_in > lsbx_pkg::PH_PAYLOAD) begin
         go = 1'b0;
      end

      if (go) begin
         bit_shift_in = {bit_shift_in[30:0], in_byte_ff[0]};
         if (phase_in == lsbx_pkg::PH_EXT_SIZE || phase_in == lsbx_pkg::PH_SIZE) begin
            full = (bit_count_in == 5'd31);
         end else begin
            full = (bit_count_in == 5'd7);
         end
         bit_count_in = bit_count_in + 5'd1;
         ch = bit_shift_in[7:0];

         if (full) begin
            case (phase_in)
               lsbx_pkg::PH_MAGIC: begin
                  if (magic_length_ff == 4'd0) begin
                     mlen = 4'd1;
                  end else if (magic_length_ff > 4'd8) begin
                     mlen = 4'd8;
                  end else begin
                     mlen = magic_length_ff;
                  end
                  sel       = 3'(mlen - 4'd1 - magic_index_in);
                  expect_ch = magic_chars_ff[{sel, 3'b000} +: 8];
                  if (ch != expect_ch) begin
                     magic_match_in = 1'b0;
                  end
                  mi_next        = magic_index_in + 4'd1;
                  magic_index_in = mi_next;
                  bit_count_in   = 5'd0;
                  bit_shift_in   = 32'd0;
                  if (mi_next >= mlen) begin
                     if (!magic_match_in) begin
                        phase_in    = lsbx_pkg::PH_DONE;
                        emit_in     = 1'b1;
                        out_kind_in = lsbx_pkg::KIND_FAIL;
                        out_last_in = 1'b1;
                     end else begin
                        phase_in = lsbx_pkg::PH_EXT_SIZE;
                     end
                  end
               end
               lsbx_pkg::PH_EXT_SIZE: begin
                  if (bit_shift_in[31] || bit_shift_in == 32'd0 ||
                      bit_shift_in > 32'(MAX_EXTENSION)) begin
                     phase_in    = lsbx_pkg::PH_DONE;
                     emit_in     = 1'b1;
                     out_kind_in = lsbx_pkg::KIND_FAIL;
                     out_last_in = 1'b1;
                  end else begin
                     extension_left_in = bit_shift_in[7:0];
                     phase_in          = lsbx_pkg::PH_EXT;
                     bit_count_in      = 5'd0;
                     bit_shift_in      = 32'd0;
                  end
               end
               lsbx_pkg::PH_EXT: begin
                  el_next           = extension_left_in - 8'd1;
                  extension_left_in = el_next;
                  phase_in     = (el_next == 8'd0) ? lsbx_pkg::PH_SIZE : lsbx_pkg::PH_EXT;
                  bit_count_in = 5'd0;
                  bit_shift_in = 32'd0;
                  emit_in      = 1'b1;
                  out_kind_in  = lsbx_pkg::KIND_EXT;
                  out_byte_in  = ch;
                  out_last_in  = 1'b0;
               end
               lsbx_pkg::PH_SIZE: begin
                  if (bit_shift_in[31] || bit_shift_in == 32'd0) begin
                     phase_in    = lsbx_pkg::PH_DONE;
                     emit_in     = 1'b1;
                     out_kind_in = lsbx_pkg::KIND_FAIL;
                     out_last_in = 1'b1;
                  end else begin
                     payload_left_in = bit_shift_in[30:0];
                     phase_in        = lsbx_pkg::PH_PAYLOAD;
                     bit_count_in    = 5'd0;
                     bit_shift_in    = 32'd0;
                  end
               end
               default: begin
                  // Payload byte
                  pl_next         = payload_left_in - 31'd1;
                  payload_left_in = pl_next;
                  phase_in     = (pl_next == 31'd0) ? lsbx_pkg::PH_DONE : lsbx_pkg::PH_PAYLOAD;
                  bit_count_in = 5'd0;
                  bit_shift_in = 32'd0;
                  emit_in      = 1'b1;
                  out_kind_in  = lsbx_pkg::KIND_PAYLOAD;
                  out_byte_in  = ch;
                  out_last_in  = (pl_next == 31'd0);
               end
            endcase
         end
      end
   end

   // Advance parse state with each decoded item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= lsbx_pkg::PH_HEADER;
         header_count_ff   <= 8'd0;
         bit_count_ff      <= 5'd0;
         bit_shift_ff      <= 32'd0;
         magic_index_ff    <= 4'd0;
         magic_match_ff    <= 1'b1;
         extension_left_ff <= 8'd0;
         payload_left_ff   <= 31'd0;
      end else if (advance) begin
         phase_ff          <= phase_in;
         header_count_ff   <= header_count_in;
         bit_count_ff      <= bit_count_in;
         bit_shift_ff      <= bit_shift_in;
         magic_index_ff    <= magic_index_in;
         magic_match_ff    <= magic_match_in;
         extension_left_ff <= extension_left_in;
         payload_left_ff   <= payload_left_in;
      end
   end

   // Result register: load on advance, drop when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit_in;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit_in) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_last_ff <= out_last_in;
      end
   end

endmodule

[src/lsbx_checker.sv]
// Port-level checks for the LSB payload extractor, bound to the top level.
`timescale 1ns / 1ps

module lsbx_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input lsbx_pkg::kind_type  rsp_kind,
   input logic [7:0]          rsp_byte,
   input logic                rsp_last
);

   // Stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_byte) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lsbx_pkg::KIND_FAIL |-> rsp_last && rsp_byte == 8'd0)
      else $error("failure item without last or with nonzero byte");

   a_ext_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == lsbx_pkg::KIND_EXT |-> !rsp_last)
      else $error("extension character marked last");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind == lsbx_pkg::KIND_EXT || rsp_kind == lsbx_pkg::KIND_PAYLOAD ||
         rsp_kind == lsbx_pkg::KIND_FAIL)
      else $error("illegal result kind");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind lsb_stego_payload_extractor lsbx_checker u_lsbx_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_kind  (rsp_chan.out_kind),
   .rsp_byte  (rsp_chan.out_byte),
   .rsp_last  (rsp_chan.last)
);
